/* rtl/adrs_pkg.sv */
`timescale 1ns / 1ps

package adrs_pkg;

	localparam int ElemW = 32;

	typedef logic signed [ElemW-1:0] elem_t;

	typedef struct packed {
		logic ins;
		logic shift;
		logic desc;
	} cell_ctl_t;

endpackage

/* rtl/adrs_cell.sv */
`timescale 1ns / 1ps

module adrs_cell
	import adrs_pkg::*;
(
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  elem_t     element,
	input  logic      occupied,
	input  elem_t     prev_value,
	input  logic      prev_after,
	input  elem_t     next_value,
	output elem_t     value,
	output logic      after
);

	elem_t value_q;
	logic  cmp_after;

	// stored value belongs behind the incoming element in this row's order
	always_comb begin
		cmp_after = ctl.desc ? (value_q < element) : (value_q > element);
		after     = !occupied || cmp_after;
	end

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (after) begin
				value_q <= prev_after ? prev_value : element;
			end
		end else if (ctl.shift) begin
			value_q <= next_value;
		end
	end

	assign value = value_q;

endmodule

/* rtl/alternating_direction_row_sorter_top.sv */
`timescale 1ns / 1ps
// channel   dir  tdata                 tlast        tuser
// s_axis    in   [31:0] element        row_end      [0] matrix_end
// m_axis    out  [31:0] sorted_element last_of_row  [0] descending, [1] dropped
//
// each input item is inserted in order into the cell chain; items past ROW_LEN are dropped
// a row of n kept elements then drains as n results, one result per cycle while m_axis_tready is high
// no input item is taken while a row drains; m_axis_tready low holds the drain
// arst_n clears the count, drain state, direction, overflow and matrix_end flags and output valid

module alternating_direction_row_sorter_top
	import adrs_pkg::*;
#(
	parameter int ROW_LEN = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] element
	input  logic        s_axis_tlast,
	input  logic        s_axis_tuser,  // [0] matrix_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [31:0] sorted_element
	output logic        m_axis_tlast,
	output logic [1:0]  m_axis_tuser   // [0] descending, [1] dropped
);

	localparam int CntW = $clog2(ROW_LEN + 1);

	logic [CntW-1:0] count_q;
	logic            draining_q;
	logic            dir_q;
	logic            ovf_q;
	logic            mend_q;

	logic            out_valid_q;
	elem_t           out_data_q;
	logic            out_last_q;
	logic            out_desc_q;
	logic            out_drop_q;

	logic            in_acc;
	logic            room;
	logic            load_out;
	logic            last_now;
	cell_ctl_t       ctl;

	elem_t           cell_value [ROW_LEN];
	logic            cell_after [ROW_LEN];

	assign s_axis_tready = !draining_q;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign room          = count_q < CntW'(ROW_LEN);
	assign load_out      = draining_q && (!out_valid_q || m_axis_tready);
	assign last_now      = count_q == CntW'(1);

	always_comb begin
		ctl.ins   = in_acc && room;
		ctl.shift = load_out;
		ctl.desc  = dir_q;
	end

	for (genvar i = 0; i < ROW_LEN; i++) begin : g_cell
		elem_t prev_v;
		logic  prev_a;
		elem_t next_v;
		logic  occ;

		if (i == 0) begin : g_first
			assign prev_v = cell_value[0];
			assign prev_a = 1'b0;
		end else begin : g_mid
			assign prev_v = cell_value[i-1];
			assign prev_a = cell_after[i-1];
		end

		if (i == ROW_LEN - 1) begin : g_last
			assign next_v = cell_value[i];
		end else begin : g_inner
			assign next_v = cell_value[i+1];
		end

		assign occ = CntW'(i) < count_q;

		adrs_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.element    (s_axis_tdata),
			.occupied   (occ),
			.prev_value (prev_v),
			.prev_after (prev_a),
			.next_value (next_v),
			.value      (cell_value[i]),
			.after      (cell_after[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			draining_q  <= 1'b0;
			dir_q       <= 1'b0;
			ovf_q       <= 1'b0;
			mend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				if (room) begin
					count_q <= count_q + CntW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
				if (s_axis_tlast) begin
					draining_q <= 1'b1;
					mend_q     <= s_axis_tuser;
				end
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
				count_q     <= count_q - CntW'(1);
				if (last_now) begin
					draining_q <= 1'b0;
					ovf_q      <= 1'b0;
					dir_q      <= mend_q ? 1'b0 : !dir_q;
				end
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= cell_value[0];
			out_last_q <= last_now;
			out_desc_q <= dir_q;
			out_drop_q <= last_now && ovf_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = {out_drop_q, out_desc_q};

endmodule

/* sim/tb_alternating_direction_row_sorter_top.sv */
`timescale 1ns / 1ps

module tb_alternating_direction_row_sorter_top;
	import adrs_pkg::*;

	localparam int RowLen = 16;
	localparam int IdleLimit = 4000;

	typedef struct {
		elem_t value;
		logic  last;
		logic  desc;
		logic  dropped;
	} sorted_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;   // [31:0] element
	logic        s_axis_tlast = 1'b0;
	logic        s_axis_tuser = 1'b0; // [0] matrix_end
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;        // [31:0] sorted_element
	logic        m_axis_tlast;
	logic [1:0]  m_axis_tuser;        // [0] descending, [1] dropped

	// predictor state
	elem_t          row_fill[$];
	logic           row_overflow = 1'b0;
	logic           snake_desc = 1'b0;
	sorted_result_t pending_sorted[$];
	sorted_result_t head_result;

	int   fail_count = 0;
	int   idle_cycles = 0;
	int   stall_left = 0;
	logic idle_enable = 1'b1;

	alternating_direction_row_sorter_top #(
		.ROW_LEN(RowLen)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser)
	);

	always #6 clk = ~clk;

	// mostly short pauses, now and then a long one
	function automatic int random_pause_len();
		if ($urandom_range(0, 9) < 9)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic elem_t random_element();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			case ($urandom_range(0, 3))
				0: return 32'sh7fffffff;
				1: return 32'sh80000000;
				2: return 32'sh0;
				default: return -32'sd1;
			endcase
		end
		if (pick < 3)
			return elem_t'($signed($urandom_range(0, 7)) - 4);
		return elem_t'($urandom);
	endfunction

	task automatic absorb_element(input elem_t value, input logic row_end,
			input logic matrix_end);
		elem_t          ordered[$];
		elem_t          held;
		int             j;
		sorted_result_t r;
		if (row_fill.size() < RowLen)
			row_fill.push_back(value);
		else
			row_overflow = 1'b1;
		if (row_end) begin
			ordered = row_fill;
			for (int i = 1; i < ordered.size(); i++) begin
				held = ordered[i];
				j = i;
				while (j > 0 && ordered[j-1] > held) begin
					ordered[j] = ordered[j-1];
					j--;
				end
				ordered[j] = held;
			end
			for (int k = 0; k < ordered.size(); k++) begin
				r.value = snake_desc ? ordered[ordered.size()-1-k] : ordered[k];
				r.last = (k == ordered.size() - 1);
				r.desc = snake_desc;
				r.dropped = r.last & row_overflow;
				pending_sorted.push_back(r);
			end
			snake_desc = matrix_end ? 1'b0 : ~snake_desc;
			row_fill.delete();
			row_overflow = 1'b0;
		end
	endtask

	task automatic send_item(input elem_t value, input logic row_end, input logic matrix_end);
		int gap;
		gap = 0;
		if (idle_enable && $urandom_range(0, 99) < 40)
			gap = random_pause_len();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= value;
		s_axis_tlast <= row_end;
		s_axis_tuser <= matrix_end;
		do
			@(posedge clk);
		while (!s_axis_tready);
		absorb_element(value, row_end, matrix_end);
	endtask

	// sink side stalls
	always @(posedge clk) begin
		if (stall_left != 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_enable && $urandom_range(0, 99) < 30) begin
			m_axis_tready <= 1'b0;
			stall_left <= random_pause_len();
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_sorted.size() == 0) begin
				$error("unexpected item: sorted_element %0d last_of_row %0b",
					$signed(m_axis_tdata), m_axis_tlast);
				fail_count++;
			end else begin
				head_result = pending_sorted.pop_front();
				if (m_axis_tdata !== head_result.value) begin
					$error("sorted_element: expected %0d, actual %0d",
						head_result.value, $signed(m_axis_tdata));
					fail_count++;
				end
				if (m_axis_tlast !== head_result.last) begin
					$error("last_of_row: expected %0b, actual %0b",
						head_result.last, m_axis_tlast);
					fail_count++;
				end
				if (m_axis_tuser[0] !== head_result.desc) begin
					$error("descending: expected %0b, actual %0b",
						head_result.desc, m_axis_tuser[0]);
					fail_count++;
				end
				if (m_axis_tuser[1] !== head_result.dropped) begin
					$error("dropped: expected %0b, actual %0b",
						head_result.dropped, m_axis_tuser[1]);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IdleLimit) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic test_extreme_values();
		send_item(32'sh7fffffff, 1'b0, 1'b0);
		send_item(32'sh80000000, 1'b0, 1'b0);
		send_item(-32'sd1, 1'b0, 1'b0);
		send_item(32'sh7fffffff, 1'b1, 1'b0);
	endtask

	task automatic test_single_item_row_ends_matrix();
		send_item(32'sh0, 1'b1, 1'b1);
	endtask

	task automatic test_matrix_end_without_row_end();
		send_item(32'sd5, 1'b0, 1'b1);
		send_item(-32'sd5, 1'b1, 1'b0);
	endtask

	task automatic test_row_overflow();
		for (int e = 1; e <= RowLen + 2; e++)
			send_item(random_element(), e == RowLen + 2, e == RowLen + 2);
	endtask

	task automatic test_back_to_back_rows();
		idle_enable = 1'b0;
		for (int e = 1; e <= RowLen; e++)
			send_item(random_element(), e == RowLen, 1'b0);
		for (int e = 1; e <= RowLen; e++)
			send_item(random_element(), e == RowLen, e == RowLen);
		idle_enable = 1'b1;
	endtask

	task automatic test_random_rows();
		int sent;
		int len;
		int unsigned pick;
		sent = 0;
		while (sent < 64) begin
			pick = $urandom_range(0, 9);
			if (pick == 0)
				len = RowLen + $urandom_range(1, 4);
			else if (pick == 1)
				len = RowLen;
			else
				len = $urandom_range(1, RowLen - 1);
			for (int e = 1; e <= len; e++) begin
				if (e == len)
					send_item(random_element(), 1'b1, $urandom_range(0, 3) == 0);
				else
					send_item(random_element(), 1'b0, 1'($urandom_range(0, 1)));
			end
			sent += len;
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extreme_values();
		test_single_item_row_ends_matrix();
		test_matrix_end_without_row_end();
		test_row_overflow();
		test_back_to_back_rows();
		test_random_rows();
		s_axis_tvalid <= 1'b0;
		while (pending_sorted.size() != 0)
			@(posedge clk);
		repeat (2 * RowLen + 10) @(posedge clk);
		if (fail_count == 0 && pending_sorted.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
